/* hw/rtl/psw_pkg.sv */
// Shared types, codes and the sequencer program of the priority software timer table.
package psw_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int NFW         = $clog2(MAX_RESULTS + 1);

    localparam int OP_W  = 2;
    localparam int ID_W  = 8;
    localparam int PRI_W = 8;
    localparam int DLY_W = 16;
    localparam int ST_W  = 3;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK           = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL         = 3'd1;
    localparam logic [ST_W-1:0] ST_REMOVE_EARLY = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_DELAY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE_FIRED   = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] prio;
        logic [DLY_W-1:0] period;
        logic [DLY_W-1:0] remain;
        logic             periodic;
    } t_entry;

    // Jump conditions of the sequencer.
    localparam int CD_W = 4;
    localparam logic [CD_W-1:0] CD_NEXT        = 4'd0;
    localparam logic [CD_W-1:0] CD_GOTO        = 4'd1;
    localparam logic [CD_W-1:0] CD_NOT_ACC     = 4'd2;
    localparam logic [CD_W-1:0] CD_CREATE      = 4'd3;
    localparam logic [CD_W-1:0] CD_REMOVE      = 4'd4;
    localparam logic [CD_W-1:0] CD_TICK        = 4'd5;
    localparam logic [CD_W-1:0] CD_DLY_ZERO    = 4'd6;
    localparam logic [CD_W-1:0] CD_FULL        = 4'd7;
    localparam logic [CD_W-1:0] CD_RD_ZERO     = 4'd8;
    localparam logic [CD_W-1:0] CD_PRI_LE      = 4'd9;
    localparam logic [CD_W-1:0] CD_RD_END      = 4'd10;
    localparam logic [CD_W-1:0] CD_ID_MATCH    = 4'd11;
    localparam logic [CD_W-1:0] CD_DEC_ZERO    = 4'd12;
    localparam logic [CD_W-1:0] CD_NOT_PER     = 4'd13;
    localparam logic [CD_W-1:0] CD_NOT_STARTED = 4'd14;

    // Table write selections.
    localparam int WS_W = 3;
    localparam logic [WS_W-1:0] WS_NONE   = 3'd0;
    localparam logic [WS_W-1:0] WS_SHIFT  = 3'd1;
    localparam logic [WS_W-1:0] WS_NEW    = 3'd2;
    localparam logic [WS_W-1:0] WS_KEEP   = 3'd3;
    localparam logic [WS_W-1:0] WS_DEC    = 3'd4;
    localparam logic [WS_W-1:0] WS_RELOAD = 3'd5;

    // Program steps.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] S_D_CR      = 5'd1;
    localparam logic [STEP_W-1:0] S_D_RM      = 5'd2;
    localparam logic [STEP_W-1:0] S_D_TK      = 5'd3;
    localparam logic [STEP_W-1:0] S_D_NOP     = 5'd4;
    localparam logic [STEP_W-1:0] S_CR_DLY    = 5'd5;
    localparam logic [STEP_W-1:0] S_CR_FULCHK = 5'd6;
    localparam logic [STEP_W-1:0] S_CR_RD     = 5'd7;
    localparam logic [STEP_W-1:0] S_CR_CMP    = 5'd8;
    localparam logic [STEP_W-1:0] S_CR_SHIFT  = 5'd9;
    localparam logic [STEP_W-1:0] S_CR_INS    = 5'd10;
    localparam logic [STEP_W-1:0] S_CR_OK     = 5'd11;
    localparam logic [STEP_W-1:0] S_CR_FULL   = 5'd12;
    localparam logic [STEP_W-1:0] S_CR_BAD    = 5'd13;
    localparam logic [STEP_W-1:0] S_RM_CHK    = 5'd14;
    localparam logic [STEP_W-1:0] S_RM_RD     = 5'd15;
    localparam logic [STEP_W-1:0] S_RM_CMP    = 5'd16;
    localparam logic [STEP_W-1:0] S_RM_KEEP   = 5'd17;
    localparam logic [STEP_W-1:0] S_RM_END    = 5'd18;
    localparam logic [STEP_W-1:0] S_RM_BAD    = 5'd19;
    localparam logic [STEP_W-1:0] S_TK_INIT   = 5'd20;
    localparam logic [STEP_W-1:0] S_TK_RD     = 5'd21;
    localparam logic [STEP_W-1:0] S_TK_DEC    = 5'd22;
    localparam logic [STEP_W-1:0] S_TK_KEEP   = 5'd23;
    localparam logic [STEP_W-1:0] S_TK_FIRE   = 5'd24;
    localparam logic [STEP_W-1:0] S_TK_RELOAD = 5'd25;
    localparam logic [STEP_W-1:0] S_TK_END    = 5'd26;

    typedef struct packed {
        logic [CD_W-1:0]   cond;
        logic [STEP_W-1:0] target;
        logic              accept;
        logic              rd_up;
        logic              rd_dn;
        logic              init_up;
        logic              init_dn;
        logic              rd_inc;
        logic [WS_W-1:0]   wsel;
        logic              occ_inc;
        logic              occ_wr;
        logic              set_started;
        logic              emit;
        logic [ST_W-1:0]   status;
        logic              fire;
        logic              flush;
        logic              tk_init;
    } t_uword;

    typedef struct packed {
        logic acc;
        logic op_create;
        logic op_remove;
        logic op_tick;
        logic dly_zero;
        logic full;
        logic rd_zero;
        logic pri_le;
        logic rd_end;
        logic id_match;
        logic dec_zero;
        logic not_per;
        logic not_started;
    } t_flags;

    // The control store: one word per step.
    function automatic t_uword uword(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            S_IDLE: begin
                w.accept = 1'b1; w.cond = CD_NOT_ACC; w.target = S_IDLE;
            end
            S_D_CR: begin
                w.cond = CD_CREATE; w.target = S_CR_DLY;
            end
            S_D_RM: begin
                w.cond = CD_REMOVE; w.target = S_RM_CHK;
            end
            S_D_TK: begin
                w.cond = CD_TICK; w.target = S_TK_INIT;
            end
            S_D_NOP: begin
                w.cond = CD_GOTO; w.target = S_IDLE;
            end
            S_CR_DLY: begin
                w.cond = CD_DLY_ZERO; w.target = S_CR_BAD;
            end
            S_CR_FULCHK: begin
                w.cond = CD_FULL; w.target = S_CR_FULL; w.init_dn = 1'b1;
            end
            S_CR_RD: begin
                w.cond = CD_RD_ZERO; w.target = S_CR_INS; w.rd_dn = 1'b1;
            end
            S_CR_CMP: begin
                w.cond = CD_PRI_LE; w.target = S_CR_INS;
            end
            S_CR_SHIFT: begin
                w.wsel = WS_SHIFT; w.cond = CD_GOTO; w.target = S_CR_RD;
            end
            S_CR_INS: begin
                w.wsel = WS_NEW; w.occ_inc = 1'b1; w.set_started = 1'b1;
            end
            S_CR_OK: begin
                w.emit = 1'b1; w.status = ST_OK; w.cond = CD_GOTO; w.target = S_IDLE;
            end
            S_CR_FULL: begin
                w.emit = 1'b1; w.status = ST_FULL; w.cond = CD_GOTO; w.target = S_IDLE;
            end
            S_CR_BAD: begin
                w.emit = 1'b1; w.status = ST_BAD_DELAY; w.cond = CD_GOTO; w.target = S_IDLE;
            end
            S_RM_CHK: begin
                w.cond = CD_NOT_STARTED; w.target = S_RM_BAD; w.init_up = 1'b1;
            end
            S_RM_RD: begin
                w.cond = CD_RD_END; w.target = S_RM_END; w.rd_up = 1'b1;
            end
            S_RM_CMP: begin
                w.rd_inc = 1'b1; w.cond = CD_ID_MATCH; w.target = S_RM_RD;
            end
            S_RM_KEEP: begin
                w.wsel = WS_KEEP; w.cond = CD_GOTO; w.target = S_RM_RD;
            end
            S_RM_END: begin
                w.occ_wr = 1'b1; w.emit = 1'b1; w.status = ST_OK;
                w.cond = CD_GOTO; w.target = S_IDLE;
            end
            S_RM_BAD: begin
                w.emit = 1'b1; w.status = ST_REMOVE_EARLY;
                w.cond = CD_GOTO; w.target = S_IDLE;
            end
            S_TK_INIT: begin
                w.init_up = 1'b1; w.tk_init = 1'b1;
            end
            S_TK_RD: begin
                w.cond = CD_RD_END; w.target = S_TK_END; w.rd_up = 1'b1;
            end
            S_TK_DEC: begin
                w.rd_inc = 1'b1; w.cond = CD_DEC_ZERO; w.target = S_TK_FIRE;
            end
            S_TK_KEEP: begin
                w.wsel = WS_DEC; w.cond = CD_GOTO; w.target = S_TK_RD;
            end
            S_TK_FIRE: begin
                w.fire = 1'b1; w.cond = CD_NOT_PER; w.target = S_TK_RD;
            end
            S_TK_RELOAD: begin
                w.wsel = WS_RELOAD; w.cond = CD_GOTO; w.target = S_TK_RD;
            end
            S_TK_END: begin
                w.occ_wr = 1'b1; w.emit = 1'b1; w.flush = 1'b1; w.status = ST_NONE_FIRED;
                w.cond = CD_GOTO; w.target = S_IDLE;
            end
            default: begin
                w.cond = CD_GOTO; w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/psw_if.sv */
// Handshake interfaces for the request and result channels.
interface psw_req_if;
    logic                        valid;
    logic                        ready;
    logic [psw_pkg::OP_W-1:0]    operation;
    logic [psw_pkg::ID_W-1:0]    task_id;
    logic [psw_pkg::PRI_W-1:0]   priority_req;
    logic [psw_pkg::DLY_W-1:0]   delay;
    logic                        periodic;

    modport source (output valid, operation, task_id, priority_req, delay, periodic,
                    input ready);
    modport sink   (input valid, operation, task_id, priority_req, delay, periodic,
                    output ready);
endinterface

interface psw_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [psw_pkg::ST_W-1:0]  status;
    logic                      fired;
    logic [psw_pkg::ID_W-1:0]  fired_id;
    logic                      last;

    modport source (output valid, status, fired, fired_id, last, input ready);
    modport sink   (input valid, status, fired, fired_id, last, output ready);
endinterface

/* hw/rtl/psw_table.sv */
// Timer slot memory: one write port and one registered read port.
module psw_table #(
    parameter int SLOTS = psw_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(SLOTS)-1:0]     i_rd_addr,
    output psw_pkg::t_entry              o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(SLOTS)-1:0]     i_wr_addr,
    input  psw_pkg::t_entry              i_wr_data
);

    psw_pkg::t_entry r_mem [SLOTS];
    psw_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/psw_seq.sv */
// Microprogram sequencer: step counter, control store and conditional jumps.
module psw_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psw_pkg::t_flags  i_flags,
    input  logic             i_stall,
    output psw_pkg::t_uword  o_ctl
);

    logic [psw_pkg::STEP_W-1:0] r_step;
    logic [psw_pkg::STEP_W-1:0] n_step;
    psw_pkg::t_uword            ctl;
    logic                       take;

    assign ctl   = psw_pkg::uword(r_step);
    assign o_ctl = ctl;

    always_comb begin
        case (ctl.cond)
            psw_pkg::CD_NEXT:        take = 1'b0;
            psw_pkg::CD_GOTO:        take = 1'b1;
            psw_pkg::CD_NOT_ACC:     take = !i_flags.acc;
            psw_pkg::CD_CREATE:      take = i_flags.op_create;
            psw_pkg::CD_REMOVE:      take = i_flags.op_remove;
            psw_pkg::CD_TICK:        take = i_flags.op_tick;
            psw_pkg::CD_DLY_ZERO:    take = i_flags.dly_zero;
            psw_pkg::CD_FULL:        take = i_flags.full;
            psw_pkg::CD_RD_ZERO:     take = i_flags.rd_zero;
            psw_pkg::CD_PRI_LE:      take = i_flags.pri_le;
            psw_pkg::CD_RD_END:      take = i_flags.rd_end;
            psw_pkg::CD_ID_MATCH:    take = i_flags.id_match;
            psw_pkg::CD_DEC_ZERO:    take = i_flags.dec_zero;
            psw_pkg::CD_NOT_PER:     take = i_flags.not_per;
            psw_pkg::CD_NOT_STARTED: take = i_flags.not_started;
            default:                 take = 1'b1;
        endcase
    end

    always_comb begin
        if (i_stall) begin
            n_step = r_step;
        end else if (take) begin
            n_step = ctl.target;
        end else begin
            n_step = r_step + psw_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= psw_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* hw/rtl/priority_software_timer_table.sv */
// Top level: request latch, slot walk datapath and result register of the timer table.
// Throughput: one request at a time, taken in the cycle after the previous one is wrapped up;
// a full result register that is not being taken stalls any step that hands a result over until it drains.
// Reset (synchronous, active low) empties the table and clears the started flag at once.
module priority_software_timer_table #(
    parameter int SLOTS = psw_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psw_req_if.sink       i_req,
    psw_rsp_if.source     o_rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Sequencer control word and the flags it branches on.
    psw_pkg::t_uword ctl;
    psw_pkg::t_flags flags;
    logic            stall;
    logic            go;

    // Latched request.
    logic [psw_pkg::OP_W-1:0]  r_op;
    logic [psw_pkg::ID_W-1:0]  r_id;
    logic [psw_pkg::PRI_W-1:0] r_pri;
    logic [psw_pkg::DLY_W-1:0] r_dly;
    logic                      r_per;

    // Table bookkeeping. Valid entries always sit in slots 0 to r_occ-1, in
    // ascending priority, so the fill count stands in for per-slot valid bits.
    logic [CW-1:0] r_occ;
    logic          r_started;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_wr;
    logic [CW-1:0] rd_m1;

    // Tick reporting: the most recent fired id is held back so that the
    // final one can carry the last marker once the walk is done.
    logic                     r_pend_v;
    logic [psw_pkg::ID_W-1:0] r_pend_id;
    logic [psw_pkg::NFW-1:0]  r_nfire;
    logic                     room;
    logic                     push_pend;

    // Result register.
    logic                      r_ov;
    logic [psw_pkg::ST_W-1:0]  r_ost;
    logic                      r_of;
    logic [psw_pkg::ID_W-1:0]  r_oid;
    logic                      r_olast;
    logic                      out_free;
    logic                      do_emit;

    // Table ports.
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    psw_pkg::t_entry rdata;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    psw_pkg::t_entry wdata;
    logic            wr_adv;

    psw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .i_stall (stall),
        .o_ctl   (ctl)
    );

    psw_table #(.SLOTS(SLOTS)) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rdata),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wdata)
    );

    assign i_req.ready = ctl.accept;

    assign rd_m1 = r_rd - CW'(1);

    always_comb begin
        flags.acc         = i_req.valid && ctl.accept;
        flags.op_create   = (r_op == psw_pkg::OP_CREATE);
        flags.op_remove   = (r_op == psw_pkg::OP_REMOVE);
        flags.op_tick     = (r_op == psw_pkg::OP_TICK);
        flags.dly_zero    = (r_dly == '0);
        flags.full        = (r_occ == CW'(SLOTS));
        flags.rd_zero     = (r_rd == '0);
        flags.pri_le      = (rdata.prio <= r_pri);
        flags.rd_end      = (r_rd == r_occ);
        flags.id_match    = (rdata.id == r_id);
        flags.dec_zero    = (rdata.remain == psw_pkg::DLY_W'(1));
        flags.not_per     = !rdata.periodic;
        flags.not_started = !r_started;
    end

    // A step that must hand a result over waits while the result register is full and not being taken.
    assign out_free  = !r_ov || o_rsp.ready;
    assign room      = (r_nfire < psw_pkg::NFW'(psw_pkg::MAX_RESULTS));
    assign push_pend = r_pend_v && room;
    assign stall     = (ctl.emit || (ctl.fire && push_pend)) && !out_free;
    assign go        = !stall;
    assign do_emit   = go && (ctl.emit || (ctl.fire && push_pend));

    // Reads never touch a slot at or past the fill count.
    assign rd_en   = go && ((ctl.rd_dn && !flags.rd_zero) || (ctl.rd_up && !flags.rd_end));
    assign rd_addr = ctl.rd_dn ? rd_m1[IW-1:0] : r_rd[IW-1:0];

    always_comb begin
        wdata   = rdata;
        wr_addr = r_wr[IW-1:0];
        wr_adv  = 1'b0;
        case (ctl.wsel)
            psw_pkg::WS_SHIFT: begin
                wr_addr = r_rd[IW-1:0];
            end
            psw_pkg::WS_NEW: begin
                wr_addr         = r_rd[IW-1:0];
                wdata.id        = r_id;
                wdata.prio      = r_pri;
                wdata.period    = r_dly;
                wdata.remain    = r_dly;
                wdata.periodic  = r_per;
            end
            psw_pkg::WS_KEEP: begin
                wr_adv = 1'b1;
            end
            psw_pkg::WS_DEC: begin
                wdata.remain = rdata.remain - psw_pkg::DLY_W'(1);
                wr_adv       = 1'b1;
            end
            psw_pkg::WS_RELOAD: begin
                wdata.remain = rdata.period;
                wr_adv       = 1'b1;
            end
            default: begin
                wr_adv = 1'b0;
            end
        endcase
    end

    assign wr_en = go && (ctl.wsel != psw_pkg::WS_NONE);

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (flags.acc) begin
            r_op  <= i_req.operation;
            r_id  <= i_req.task_id;
            r_pri <= i_req.priority_req;
            r_dly <= i_req.delay;
            r_per <= i_req.periodic;
        end
    end

    // Walk pointers. A create walks down from the top and shifts larger
    // priorities up by one; remove and tick walk up and compact as they go.
    always_ff @(posedge i_clk) begin
        if (go) begin
            if (ctl.init_up) begin
                r_rd <= '0;
            end else if (ctl.init_dn) begin
                r_rd <= r_occ;
            end else if (ctl.rd_inc) begin
                r_rd <= r_rd + CW'(1);
            end else if (ctl.wsel == psw_pkg::WS_SHIFT) begin
                r_rd <= rd_m1;
            end
            if (ctl.init_up) begin
                r_wr <= '0;
            end else if (wr_adv) begin
                r_wr <= r_wr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_started <= 1'b0;
            r_pend_v  <= 1'b0;
            r_nfire   <= '0;
        end else if (go) begin
            if (ctl.occ_inc) begin
                r_occ <= r_occ + CW'(1);
            end else if (ctl.occ_wr) begin
                r_occ <= r_wr;
            end
            if (ctl.set_started) begin
                r_started <= 1'b1;
            end
            if (ctl.tk_init) begin
                r_pend_v <= 1'b0;
                r_nfire  <= '0;
            end else if (ctl.fire && room) begin
                r_pend_v <= 1'b1;
                r_nfire  <= r_nfire + psw_pkg::NFW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && ctl.fire && room) begin
            r_pend_id <= rdata.id;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (do_emit) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            if (ctl.fire) begin
                r_ost   <= psw_pkg::ST_OK;
                r_of    <= 1'b1;
                r_oid   <= r_pend_id;
                r_olast <= 1'b0;
            end else if (ctl.flush && r_pend_v) begin
                r_ost   <= psw_pkg::ST_OK;
                r_of    <= 1'b1;
                r_oid   <= r_pend_id;
                r_olast <= 1'b1;
            end else begin
                r_ost   <= ctl.status;
                r_of    <= 1'b0;
                r_oid   <= '0;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_rsp.valid    = r_ov;
    assign o_rsp.status   = r_ost;
    assign o_rsp.fired    = r_of;
    assign o_rsp.fired_id = r_oid;
    assign o_rsp.last     = r_olast;

endmodule

/* hw/rtl/psw_chk.sv */
// Port-level assertions for the timer table and their bind to the top level.
module psw_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [psw_pkg::ST_W-1:0]  i_out_status,
    input logic                      i_out_fired,
    input logic [psw_pkg::ID_W-1:0]  i_out_fired_id,
    input logic                      i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_fired |-> i_out_status == psw_pkg::ST_OK)
        else $error("fired beat with a non-ok status");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_fired |-> i_out_last && i_out_fired_id == '0)
        else $error("non-fired beat is not a lone final beat with a zero id");

    a_busy_mid_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("new request taken before a tick finished reporting");

endmodule

bind priority_software_timer_table psw_chk u_psw_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_status   (o_rsp.status),
    .i_out_fired    (o_rsp.fired),
    .i_out_fired_id (o_rsp.fired_id),
    .i_out_last     (o_rsp.last)
);

/* bench/priority_software_timer_table_test.sv */
// Self-checking testbench for the priority software timer table: directed and random requests.
module priority_software_timer_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = psw_pkg::SLOTS_DEF;
    // The result channel is held off this long once, while requests keep coming.
    localparam int RX_HOLD_CYCLES = 300;
    // The longest legal quiet stretch is the hold-off above. A full-table tick with
    // every result stalled by the longest receiver gap stays well under it.
    localparam int IDLE_LIMIT     = 3000;
    // The drain gives stray results time to show up after the last expected one.
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_ITEMS   = 305;
    localparam logic [psw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [psw_pkg::OP_W-1:0]  op;
        logic [psw_pkg::ID_W-1:0]  id;
        logic [psw_pkg::PRI_W-1:0] prio;
        logic [psw_pkg::DLY_W-1:0] delay;
        logic                      periodic;
    } t_req;

    typedef struct packed {
        logic [psw_pkg::ST_W-1:0] status;
        logic                     fired;
        logic [psw_pkg::ID_W-1:0] fired_id;
        logic                     last;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    psw_req_if req_if ();
    psw_rsp_if rsp_if ();

    priority_software_timer_table #(
        .SLOTS (SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Requests waiting to be driven, and results the table is known to owe us.
    t_req pending_reqs[$];
    t_rsp owed_results[$];

    // Shadow copy of the timer table. Live entries always sit in 0 .. timer_count-1,
    // sorted by priority with ties in creation order.
    psw_pkg::t_entry timer_slots[SLOTS];
    int              timer_count;
    bit              timers_started;

    int mismatches;
    int beats_in;
    int idle_cycles;
    bit rx_hold;

    int tx_gap;
    int tx_beats;
    bit tx_burst;
    int rx_stall;
    int rx_cycles;
    bit rx_burst;

    // Most gaps are short and a few are long. In burst mode there are none at all.
    function automatic int draw_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void owe_result(input logic [psw_pkg::ST_W-1:0] st, input logic f,
                                       input logic [psw_pkg::ID_W-1:0] fid, input logic lst);
        owed_results.push_back('{status: st, fired: f, fired_id: fid, last: lst});
    endfunction

    // Applies one accepted request to the shadow table and queues the results it causes.
    function automatic void predict_timer_table(input t_req r);
        psw_pkg::t_entry e;
        int              pos;
        int              i;
        int              kept;
        int              n_fired;
        case (r.op)
            psw_pkg::OP_CREATE: begin
                if (r.delay == '0) begin
                    owe_result(psw_pkg::ST_BAD_DELAY, 1'b0, '0, 1'b1);
                end else if (timer_count >= SLOTS) begin
                    owe_result(psw_pkg::ST_FULL, 1'b0, '0, 1'b1);
                end else begin
                    // Insert after every entry of lower or equal priority.
                    pos = 0;
                    while (pos < timer_count && timer_slots[pos].prio <= r.prio) begin
                        pos++;
                    end
                    for (i = timer_count; i > pos; i--) begin
                        timer_slots[i] = timer_slots[i-1];
                    end
                    timer_slots[pos] = '{id: r.id, prio: r.prio, period: r.delay,
                                         remain: r.delay, periodic: r.periodic};
                    timer_count++;
                    timers_started = 1'b1;
                    owe_result(psw_pkg::ST_OK, 1'b0, '0, 1'b1);
                end
            end
            psw_pkg::OP_REMOVE: begin
                if (!timers_started) begin
                    owe_result(psw_pkg::ST_REMOVE_EARLY, 1'b0, '0, 1'b1);
                end else begin
                    kept = 0;
                    for (i = 0; i < timer_count; i++) begin
                        if (timer_slots[i].id != r.id) begin
                            timer_slots[kept] = timer_slots[i];
                            kept++;
                        end
                    end
                    timer_count = kept;
                    owe_result(psw_pkg::ST_OK, 1'b0, '0, 1'b1);
                end
            end
            psw_pkg::OP_TICK: begin
                // Decrement, fire in table order, reload periodic entries and
                // squeeze out expired one-shot entries while keeping the order.
                kept    = 0;
                n_fired = 0;
                for (i = 0; i < timer_count; i++) begin
                    e = timer_slots[i];
                    e.remain = e.remain - 1'b1;
                    if (e.remain == '0) begin
                        if (n_fired < psw_pkg::MAX_RESULTS) begin
                            owe_result(psw_pkg::ST_OK, 1'b1, e.id, 1'b0);
                            n_fired++;
                        end
                        e.remain = e.period;
                    end
                    if (e.remain != e.period || e.periodic || timer_slots[i].remain != 1) begin
                        timer_slots[kept] = e;
                        kept++;
                    end
                end
                timer_count = kept;
                if (n_fired == 0) begin
                    owe_result(psw_pkg::ST_NONE_FIRED, 1'b0, '0, 1'b1);
                end else begin
                    owed_results[owed_results.size()-1].last = 1'b1;
                end
            end
            default: begin
                // The unused operation code is dropped without a result.
            end
        endcase
    endfunction

    function automatic void add_req(input logic [psw_pkg::OP_W-1:0] op, input int id,
                                    input int prio, input int delay, input bit periodic);
        pending_reqs.push_back('{op: op, id: id[psw_pkg::ID_W-1:0],
                                 prio: prio[psw_pkg::PRI_W-1:0],
                                 delay: delay[psw_pkg::DLY_W-1:0], periodic: periodic});
    endfunction

    // Ids mostly come from a small pool so that removes find their targets.
    function automatic int pick_id();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(0, 9);
        end
        return $urandom_range(0, 255);
    endfunction

    // Mostly well-formed traffic: creates with short delays and plenty of ticks so
    // that timers expire, reload and free up slots; zero delays, full-range values
    // and the unused operation code are mixed in as noise.
    function automatic void add_random_reqs(input int count);
        int k;
        int r;
        int id;
        int prio;
        int delay;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 42) begin
                prio = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 255);
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    id    = $urandom_range(0, 255);
                    delay = 0;
                end else if (r < 80) begin
                    id    = pick_id();
                    delay = $urandom_range(1, 6);
                end else if (r < 92) begin
                    id    = pick_id();
                    delay = $urandom_range(7, 40);
                end else begin
                    // Long timers only get pool ids, so a remove can reclaim them.
                    id    = $urandom_range(0, 9);
                    delay = $urandom_range(1, 65535);
                end
                add_req(psw_pkg::OP_CREATE, id, prio, delay, 1'($urandom_range(0, 1)));
            end else if (r < 82) begin
                add_req(psw_pkg::OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            end else if (r < 96) begin
                add_req(psw_pkg::OP_REMOVE, pick_id(), $urandom_range(0, 255),
                        $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            end else begin
                add_req(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            end
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every input of the block is known from time zero; reset is held low at the start.
    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.operation    = '0;
        req_if.task_id      = '0;
        req_if.priority_req = '0;
        req_if.delay        = '0;
        req_if.periodic     = 1'b0;
        rsp_if.ready        = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Request driver. A new beat goes out only once the previous one has been taken,
    // after a random gap that lets idle cycles fall on every phase of the slot walk.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (tx_gap > 0) begin
                tx_gap       <= tx_gap - 1;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_if.operation    <= pending_reqs[0].op;
                req_if.task_id      <= pending_reqs[0].id;
                req_if.priority_req <= pending_reqs[0].prio;
                req_if.delay        <= pending_reqs[0].delay;
                req_if.periodic     <= pending_reqs[0].periodic;
                req_if.valid        <= 1'b1;
                void'(pending_reqs.pop_front());
                tx_gap   <= draw_gap(tx_burst);
                tx_beats <= tx_beats + 1;
                // Every 40 beats, decide whether the next stretch runs without gaps.
                if (tx_beats % 40 == 39) begin
                    tx_burst <= ($urandom_range(0, 2) == 0);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Every request beat taken by the block goes through the shadow table.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_timer_table('{op: req_if.operation, id: req_if.task_id,
                                  prio: req_if.priority_req, delay: req_if.delay,
                                  periodic: req_if.periodic});
            beats_in <= beats_in + 1;
        end
    end

    // Result receiver: random stalls, stall-free stretches, and the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
            end else if ($urandom_range(0, 99) < 25) begin
                rx_stall <= draw_gap(rx_burst);
            end
            rsp_if.ready <= !rx_hold && (rx_stall == 0);
            rx_cycles    <= rx_cycles + 1;
            if (rx_cycles % 200 == 199) begin
                rx_burst <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Once traffic is flowing, starve the result side so the output register fills,
    // the walk stalls and the request side backs up behind it.
    initial begin
        rx_hold = 1'b0;
        wait (beats_in >= 80);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Result checker: each beat is compared with the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (owed_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) begin
                    $display("unexpected result at %0t: status %0d fired %0b id %0d last %0b",
                             $time, rsp_if.status, rsp_if.fired, rsp_if.fired_id, rsp_if.last);
                end
            end else begin
                if (rsp_if.status !== owed_results[0].status
                        || rsp_if.fired !== owed_results[0].fired
                        || rsp_if.fired_id !== owed_results[0].fired_id
                        || rsp_if.last !== owed_results[0].last) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch at %0t: expected status %0d fired %0b id %0d last %0b",
                                 $time, owed_results[0].status, owed_results[0].fired,
                                 owed_results[0].fired_id, owed_results[0].last);
                        $display("    got status %0d fired %0b id %0d last %0b",
                                 rsp_if.status, rsp_if.fired, rsp_if.fired_id, rsp_if.last);
                    end
                end
                void'(owed_results.pop_front());
            end
        end
    end

    // Watchdog: too long without a beat on either channel means the block is stuck.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL priority_software_timer_table");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        mismatches     = 0;
        beats_in       = 0;
        idle_cycles    = 0;
        timer_count    = 0;
        timers_started = 1'b0;
        tx_gap         = 0;
        tx_beats       = 0;
        tx_burst       = 1'b0;
        rx_stall       = 0;
        rx_cycles      = 0;
        rx_burst       = 1'b0;

        // Before any create: a tick on an empty table, an early remove, and a zero
        // delay, which is refused and must not count as the first create.
        add_req(psw_pkg::OP_TICK, 0, 0, 0, 0);
        add_req(psw_pkg::OP_REMOVE, 5, 0, 0, 0);
        add_req(psw_pkg::OP_CREATE, 255, 255, 0, 1);
        add_req(psw_pkg::OP_REMOVE, 0, 0, 0, 0);
        // The unused code with every bit set gives nothing back.
        add_req(OP_UNUSED, 255, 255, 65535, 1);
        // Fill the table with extreme ids, priorities and delays, priority ties
        // among both one-shot and periodic entries, and a duplicate id.
        add_req(psw_pkg::OP_CREATE, 0, 255, 1, 0);
        add_req(psw_pkg::OP_CREATE, 255, 0, 65535, 1);
        add_req(psw_pkg::OP_CREATE, 1, 128, 2, 1);
        add_req(psw_pkg::OP_CREATE, 2, 128, 2, 0);
        add_req(psw_pkg::OP_CREATE, 3, 128, 1, 0);
        add_req(psw_pkg::OP_CREATE, 4, 0, 1, 1);
        add_req(psw_pkg::OP_CREATE, 4, 200, 3, 0);
        add_req(psw_pkg::OP_CREATE, 5, 7, 2, 1);
        // One more create on the full table is turned away.
        add_req(psw_pkg::OP_CREATE, 6, 1, 1, 0);
        // Three entries expire at once and come out in priority order.
        add_req(psw_pkg::OP_TICK, 0, 0, 0, 0);
        // Remove drops both entries that share id 4, then a remove that finds nothing.
        add_req(psw_pkg::OP_REMOVE, 4, 0, 0, 0);
        add_req(psw_pkg::OP_REMOVE, 77, 0, 0, 0);
        add_req(psw_pkg::OP_TICK, 0, 0, 0, 0);
        add_req(psw_pkg::OP_REMOVE, 255, 0, 0, 0);
        // Top the table up so all eight entries expire on the same tick.
        add_req(psw_pkg::OP_CREATE, 10, 250, 2, 0);
        add_req(psw_pkg::OP_CREATE, 11, 3, 2, 0);
        add_req(psw_pkg::OP_CREATE, 12, 128, 2, 0);
        add_req(psw_pkg::OP_CREATE, 13, 7, 2, 0);
        add_req(psw_pkg::OP_CREATE, 14, 0, 2, 0);
        add_req(psw_pkg::OP_CREATE, 15, 60, 2, 1);
        add_req(psw_pkg::OP_TICK, 0, 0, 0, 0);
        add_req(psw_pkg::OP_TICK, 0, 0, 0, 0);

        add_random_reqs(RANDOM_ITEMS);

        // Wait for the last request beat to be taken, then for every owed result,
        // then give the block time to show any result it should not produce.
        while (pending_reqs.size() != 0 || req_if.valid) begin
            @(posedge i_clk);
        end
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("PASS priority_software_timer_table");
        end else begin
            $display("FAIL priority_software_timer_table");
        end
        $finish;
    end

endmodule
